>>> rtl/core/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Item types for the byte and pixel channels, register map codes.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_res;
		logic       image_done;
	} pixel_item_t;

	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_COMPRESSED      = 2'd0,
		REG_BYTES_PER_PIXEL = 2'd1,
		REG_PIXEL_COUNT     = 2'd2
	} reg_index_t;

	localparam logic [2:0]  BPP_RESET   = 3'd3;
	localparam logic [2:0]  BPP_FOUR    = 3'd4;
	localparam logic [31:0] COUNT_RESET = 32'd1;

endpackage

>>> rtl/core/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes raw or run-length TGA pixel data (24/32 bit) one byte per item.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and gives one pixel item per finished pixel
// (RGBA plus repeat count), registered in the cycle after its last byte. The
// decoder state is updated once per byte, so a byte is taken every cycle unless
// the output register holds an item that is stalled. Set first on the byte
// after the header to restart; pixel_count is latched then. Bytes past the
// last pixel are dropped until the next restart. Registers: 0 compressed,
// 4 bytes_per_pixel, 8 pixel_count; write only while idle.
module tga_rle_pixel_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  tga_rle_pkg::byte_item_t             byte_item,
	output logic                                pixel_valid,
	input  logic                                pixel_stall,
	output tga_rle_pkg::pixel_item_t            pixel_item,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tga_rle_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic        compressed_q;
	logic [2:0]  bytes_per_pixel_q;
	logic [31:0] pixel_count_q;

	logic        await_q, repeat_q, finished_q;
	logic [7:0]  ppl_q;
	logic [1:0]  bip_q;
	logic [7:0]  color_q [3];
	logic [31:0] remaining_q;

	logic        await_c, repeat_c, finished_c;
	logic [7:0]  ppl_c;
	logic [1:0]  bip_c;
	logic [7:0]  color_c [3];
	logic [31:0] remaining_c;

	logic        await_n, repeat_n, finished_n;
	logic [7:0]  ppl_n;
	logic [1:0]  bip_n;
	logic [7:0]  color_n [3];
	logic [31:0] remaining_n;

	logic        accept, emit, bpp4, complete, active;
	logic [7:0]  b, run_raw, run_clip, run, ppl_next, alpha;
	tga_rle_pkg::reg_index_t reg_idx;
	tga_rle_pkg::pixel_item_t result;

	assign pready     = 1'b1;
	assign reg_idx    = tga_rle_pkg::reg_index_t'(paddr[3:2]);
	assign byte_stall = pixel_valid & pixel_stall;
	assign accept     = byte_valid & ~byte_stall;
	assign b          = byte_item.data_byte;
	assign bpp4       = (bytes_per_pixel_q == tga_rle_pkg::BPP_FOUR);

	always_comb begin
		case (reg_idx)
			tga_rle_pkg::REG_COMPRESSED:      prdata = {31'd0, compressed_q};
			tga_rle_pkg::REG_BYTES_PER_PIXEL: prdata = {29'd0, bytes_per_pixel_q};
			tga_rle_pkg::REG_PIXEL_COUNT:     prdata = pixel_count_q;
			default:                          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_q      <= 1'b0;
			bytes_per_pixel_q <= tga_rle_pkg::BPP_RESET;
			pixel_count_q     <= tga_rle_pkg::COUNT_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				tga_rle_pkg::REG_COMPRESSED:      compressed_q      <= pwdata[0];
				tga_rle_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= pwdata[2:0];
				tga_rle_pkg::REG_PIXEL_COUNT:     pixel_count_q     <= pwdata;
				default: ;
			endcase
		end
	end

	// restart applied first
	always_comb begin
		if (byte_item.first) begin
			await_c     = 1'b1;
			repeat_c    = 1'b0;
			finished_c  = 1'b0;
			ppl_c       = 8'd0;
			bip_c       = 2'd0;
			color_c[0]  = 8'd0;
			color_c[1]  = 8'd0;
			color_c[2]  = 8'd0;
			remaining_c = pixel_count_q;
		end else begin
			await_c     = await_q;
			repeat_c    = repeat_q;
			finished_c  = finished_q;
			ppl_c       = ppl_q;
			bip_c       = bip_q;
			color_c     = color_q;
			remaining_c = remaining_q;
		end
	end

	always_comb begin
		active   = ~finished_c && (remaining_c != 32'd0);
		complete = bpp4 ? (bip_c == 2'd3) : (bip_c >= 2'd2);
		run_raw  = (ppl_c == 8'd0) ? 8'd1 : ppl_c;
		run_clip = (remaining_c < {24'd0, run_raw}) ? remaining_c[7:0] : run_raw;
		run      = (compressed_q && repeat_c) ? run_clip : 8'd1;
		alpha    = (bpp4 && bip_c == 2'd3) ? b : 8'd0;

		if (repeat_c)
			ppl_next = 8'd0;
		else if (ppl_c != 8'd0)
			ppl_next = ppl_c - 8'd1;
		else
			ppl_next = ppl_c;

		await_n     = await_c;
		repeat_n    = repeat_c;
		finished_n  = finished_c;
		ppl_n       = ppl_c;
		bip_n       = bip_c;
		color_n     = color_c;
		remaining_n = remaining_c;
		emit        = 1'b0;

		if (active) begin
			if (compressed_q && await_c) begin
				// header: literal h+1 or repeat h-127, both low seven bits plus one
				repeat_n = b[7];
				ppl_n    = {1'b0, b[6:0]} + 8'd1;
				await_n  = 1'b0;
				bip_n    = 2'd0;
			end else begin
				case (bip_c)
					2'd0:    color_n[0] = b;
					2'd1:    color_n[1] = b;
					2'd2:    color_n[2] = b;
					default: ;
				endcase
				if (!complete) begin
					bip_n = bip_c + 2'd1;
				end else begin
					bip_n = 2'd0;
					emit  = 1'b1;
					if (compressed_q) begin
						ppl_n = ppl_next;
						if (ppl_next == 8'd0)
							await_n = 1'b1;
					end
					remaining_n = remaining_c - {24'd0, run};
					finished_n  = (remaining_n == 32'd0);
				end
			end
		end

		result.red        = color_n[2];
		result.green      = color_n[1];
		result.blue       = color_n[0];
		result.alpha      = alpha;
		result.repeat_res = run;
		result.image_done = finished_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q     <= 1'b1;
			repeat_q    <= 1'b0;
			finished_q  <= 1'b0;
			ppl_q       <= 8'd0;
			bip_q       <= 2'd0;
			color_q[0]  <= 8'd0;
			color_q[1]  <= 8'd0;
			color_q[2]  <= 8'd0;
			remaining_q <= 32'd0;
		end else if (accept) begin
			await_q     <= await_n;
			repeat_q    <= repeat_n;
			finished_q  <= finished_n;
			ppl_q       <= ppl_n;
			bip_q       <= bip_n;
			color_q     <= color_n;
			remaining_q <= remaining_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (!byte_stall) begin
			pixel_valid <= accept & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pixel_item <= result;
		end
	end

endmodule
